// File: hdl/selg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selg_pkg: shared types and constants for the sonar echo longest gap unit
// Field widths of the result word and fixed constants of the echo scale.
// ----------------------------------------------------------------------------
package selg_pkg;

	localparam int SAMPLE_W     = 8;
	localparam int RUN_START_W  = 11;
	localparam int RUN_LENGTH_W = 12;
	localparam int DISTANCE_W   = 16;

	// One sample step of the echo is 27/4 mm, so distance is start * 27 in quarter mm.
	localparam int unsigned DIST_PER_SAMPLE_QMM = 27;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 8'd80;

	typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

// File: hdl/selg_run_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selg_run_tracker: quiet run tracking over one echo record
// Holds the record state, updates it for one word per cycle while advance is
// high, and presents the longest quiet run once the record's last word closes it.
// ----------------------------------------------------------------------------
module selg_run_tracker
	import selg_pkg::*;
#(
	parameter int MAX_SAMPLES = 2048
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  sample_t                            sample,
	input  logic                               last,
	input  sample_t                            threshold,
	output logic                               res_found,
	output logic [$clog2(MAX_SAMPLES)-1:0]     res_start,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]   res_length
);

	localparam int IDX_W = $clog2(MAX_SAMPLES + 1);
	localparam int POS_W = $clog2(MAX_SAMPLES);
	localparam int LEN_W = IDX_W;

	logic [IDX_W-1:0] idx_q;
	logic             in_run_q;
	logic [POS_W-1:0] cur_start_q;
	logic [LEN_W-1:0] cur_len_q;
	logic [POS_W-1:0] best_start_q;
	logic [LEN_W-1:0] best_len_q;

	logic [IDX_W-1:0] idx_d;
	logic             in_run_d;
	logic [POS_W-1:0] cur_start_d;
	logic [LEN_W-1:0] cur_len_d;
	logic [POS_W-1:0] best_start_d;
	logic [LEN_W-1:0] best_len_d;

	logic active;
	logic quiet;

	assign active = idx_q < IDX_W'(MAX_SAMPLES);
	assign quiet  = sample < threshold;

	always_comb begin
		idx_d        = idx_q;
		in_run_d     = in_run_q;
		cur_start_d  = cur_start_q;
		cur_len_d    = cur_len_q;
		best_start_d = best_start_q;
		best_len_d   = best_len_q;

		if (active) begin
			if (quiet) begin
				if (!in_run_q) begin
					cur_start_d = idx_q[POS_W-1:0];
					cur_len_d   = LEN_W'(1);
				end else begin
					cur_len_d = cur_len_q + LEN_W'(1);
				end
				in_run_d = 1'b1;
			end else if (in_run_q) begin
				if (cur_len_q > best_len_q) begin
					best_len_d   = cur_len_q;
					best_start_d = cur_start_q;
				end
				in_run_d  = 1'b0;
				cur_len_d = '0;
			end
			idx_d = idx_q + IDX_W'(1);
		end

		// A run still open on the last word counts as closed; ties keep the earlier run.
		res_start  = best_start_d;
		res_length = best_len_d;
		if (in_run_d && (cur_len_d > best_len_d)) begin
			res_start  = cur_start_d;
			res_length = cur_len_d;
		end
		res_found = res_length != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			in_run_q     <= 1'b0;
			cur_start_q  <= '0;
			cur_len_q    <= '0;
			best_start_q <= '0;
			best_len_q   <= '0;
		end else if (advance) begin
			if (last) begin
				idx_q        <= '0;
				in_run_q     <= 1'b0;
				cur_start_q  <= '0;
				cur_len_q    <= '0;
				best_start_q <= '0;
				best_len_q   <= '0;
			end else begin
				idx_q        <= idx_d;
				in_run_q     <= in_run_d;
				cur_start_q  <= cur_start_d;
				cur_len_q    <= cur_len_d;
				best_start_q <= best_start_d;
				best_len_q   <= best_len_d;
			end
		end
	end

`ifndef SYNTHESIS
	a_open_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		in_run_q == (cur_len_q != '0))
		else $error("open run flag disagrees with run length");

	a_run_within_record: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_len_q <= idx_q) && (best_len_q <= idx_q))
		else $error("run length exceeds samples taken");

	a_record_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last |=> (idx_q == '0) && !in_run_q && (best_len_q == '0))
		else $error("record state not cleared after last word");
`endif

endmodule

// File: hdl/selg_result_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selg_result_reg: result register of the longest gap unit
// Captures the closed run, scales the start index to a distance and holds
// the result word until the receiver takes it.
// ----------------------------------------------------------------------------
module selg_result_reg
	import selg_pkg::*;
#(
	parameter int MAX_SAMPLES = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  logic                              res_found,
	input  logic [$clog2(MAX_SAMPLES)-1:0]    res_start,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]  res_length,
	output logic                              space,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [RUN_START_W-1:0]            run_start,
	output logic [RUN_LENGTH_W-1:0]           run_length,
	output logic [DISTANCE_W-1:0]             distance_qmm
);

	logic        valid_q;
	logic        found_q;
	logic [31:0] start_ext;
	logic [31:0] length_ext;
	logic [31:0] dist_full;

	assign start_ext  = 32'(res_start);
	assign length_ext = 32'(res_length);
	assign dist_full  = start_ext * DIST_PER_SAMPLE_QMM;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign found     = found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			found_q      <= res_found;
			run_start    <= start_ext[RUN_START_W-1:0];
			run_length   <= length_ext[RUN_LENGTH_W-1:0];
			distance_qmm <= dist_full[DISTANCE_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> space)
		else $error("result loaded while the held word is not taken");
`endif

endmodule

// File: hdl/sonar_echo_longest_gap_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_echo_longest_gap_unit: longest quiet run in a sonar echo record
// Finds the longest run of samples below low_threshold and reports its
// start, length and distance when the record's last sample arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one echo sample per word, with
//   last marking the final sample of a record. Output channel
//   (out_valid/out_ready) carries one result word per record.
//   cfg_wr_en/cfg_wr_data write low_threshold; write it only while the unit
//   is idle.
//   A result word takes this path: the last sample sits in the input register
//   until the result register has room, then the tracker update loads the
//   result register.
//   Throughput: one sample per cycle while no last sample waits for room;
//   the tracker state update is the only loop.
//   Reset clears the record state, empties both registers and sets
//   low_threshold to 80.
//   When the receiver stalls, non-last samples keep flowing; a last sample
//   waits in the input register until the held result is taken, and
//   in_ready is low only while it waits.
// ----------------------------------------------------------------------------
module sonar_echo_longest_gap_unit
	import selg_pkg::*;
#(
	parameter int MAX_SAMPLES = 2048
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_W-1:0]     sample,
	input  logic                    last,
	input  logic                    cfg_wr_en,
	input  logic [SAMPLE_W-1:0]     cfg_wr_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic [RUN_START_W-1:0]  run_start,
	output logic [RUN_LENGTH_W-1:0] run_length,
	output logic [DISTANCE_W-1:0]   distance_qmm
);

	localparam int POS_W = $clog2(MAX_SAMPLES);
	localparam int LEN_W = $clog2(MAX_SAMPLES + 1);

	sample_t    threshold_q;
	logic       valid_s1;
	sample_t    sample_s1;
	logic       last_s1;

	logic             advance;
	logic             space;
	logic             res_found;
	logic [POS_W-1:0] res_start;
	logic [LEN_W-1:0] res_length;

	// A word that ends a record moves on only when the result register has room.
	assign advance  = valid_s1 && (!last_s1 || space);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				threshold_q <= cfg_wr_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sample_s1 <= sample;
			last_s1   <= last;
		end
	end

	selg_run_tracker #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.sample    (sample_s1),
		.last      (last_s1),
		.threshold (threshold_q),
		.res_found (res_found),
		.res_start (res_start),
		.res_length(res_length)
	);

	selg_result_reg #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance && last_s1),
		.res_found   (res_found),
		.res_start   (res_start),
		.res_length  (res_length),
		.space       (space),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.run_start   (run_start),
		.run_length  (run_length),
		.distance_qmm(distance_qmm)
	);

`ifndef SYNTHESIS
	a_last_waits_for_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !space |=> valid_s1 && last_s1)
		else $error("stalled last word left the input register");

	a_plain_word_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !last_s1 |-> in_ready)
		else $error("input stalled on a word that ends no record");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the sonar echo longest gap unit
// Drives echo records through the valid/ready input channel, predicts the
// longest quiet run of each record and checks every result word field by
// field. Covers a directed table, random records at several thresholds
// and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import selg_pkg::*;

	localparam int MAX_RECORD = 2048;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic                    found;
		logic [RUN_START_W-1:0]  run_start;
		logic [RUN_LENGTH_W-1:0] run_length;
		logic [DISTANCE_W-1:0]   distance_qmm;
	} echo_result_t;

	typedef struct packed {
		sample_t      smp;
		logic         lst;
		logic         typed;
		echo_result_t res;
	} stim_row_t;

	localparam echo_result_t NONE_DUE = '0;

	// Directed records at the reset threshold of 80. Rows with typed set carry
	// their result; the others rely on the run tracker below.
	localparam stim_row_t DIRECTED_ROWS [0:23] = '{
		'{8'd0,   1'b1, 1'b1, '{1'b1, 11'd0, 12'd1, 16'd0}},
		'{8'd255, 1'b1, 1'b1, '{1'b0, 11'd0, 12'd0, 16'd0}},
		'{8'd80,  1'b0, 1'b0, NONE_DUE},
		'{8'd79,  1'b1, 1'b1, '{1'b1, 11'd1, 12'd1, 16'd27}},
		'{8'd10,  1'b0, 1'b0, NONE_DUE},
		'{8'd200, 1'b0, 1'b0, NONE_DUE},
		'{8'd20,  1'b0, 1'b0, NONE_DUE},
		'{8'd90,  1'b1, 1'b0, NONE_DUE},
		'{8'd5,   1'b0, 1'b0, NONE_DUE},
		'{8'd100, 1'b0, 1'b0, NONE_DUE},
		'{8'd1,   1'b0, 1'b0, NONE_DUE},
		'{8'd2,   1'b0, 1'b0, NONE_DUE},
		'{8'd3,   1'b0, 1'b0, NONE_DUE},
		'{8'd255, 1'b1, 1'b0, NONE_DUE},
		'{8'd100, 1'b0, 1'b0, NONE_DUE},
		'{8'd0,   1'b0, 1'b0, NONE_DUE},
		'{8'd50,  1'b0, 1'b0, NONE_DUE},
		'{8'd79,  1'b1, 1'b0, NONE_DUE},
		'{8'd0,   1'b0, 1'b0, NONE_DUE},
		'{8'd0,   1'b0, 1'b0, NONE_DUE},
		'{8'd200, 1'b0, 1'b0, NONE_DUE},
		'{8'd1,   1'b0, 1'b0, NONE_DUE},
		'{8'd1,   1'b0, 1'b0, NONE_DUE},
		'{8'd1,   1'b1, 1'b0, NONE_DUE}
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	sample_t                 sample = '0;
	logic                    last = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	sample_t                 cfg_wr_data = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    found;
	logic [RUN_START_W-1:0]  run_start;
	logic [RUN_LENGTH_W-1:0] run_length;
	logic [DISTANCE_W-1:0]   distance_qmm;

	// Run tracker state, mirroring the record state of the block.
	sample_t                 thr_model = THRESHOLD_RESET;
	logic [RUN_LENGTH_W-1:0] rec_index = '0;
	logic                    quiet_open = 1'b0;
	logic [RUN_START_W-1:0]  open_start = '0;
	logic [RUN_LENGTH_W-1:0] open_len = '0;
	logic [RUN_START_W-1:0]  best_start = '0;
	logic [RUN_LENGTH_W-1:0] best_len = '0;

	echo_result_t echo_results_due [$];
	echo_result_t due_head;
	int           mismatches = 0;
	int           cycle_count = 0;
	int           tx_gap_pct = 0;
	int           rx_stall_pct = 0;
	int           words_sent = 0;

	sonar_echo_longest_gap_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.last         (last),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.run_start    (run_start),
		.run_length   (run_length),
		.distance_qmm (distance_qmm)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top failed");
		$finish;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	function automatic void close_open_run();
		if (quiet_open) begin
			// A tie keeps the earlier run.
			if (open_len > best_len) begin
				best_len = open_len;
				best_start = open_start;
			end
			quiet_open = 1'b0;
			open_len = '0;
		end
	endfunction

	function automatic bit track_quiet_run(input sample_t s, input logic l,
		output echo_result_t r);
		r = NONE_DUE;
		// Samples past the end of a full record are dropped, but last still counts.
		if (rec_index < MAX_RECORD) begin
			if (s < thr_model) begin
				if (!quiet_open) begin
					quiet_open = 1'b1;
					open_start = rec_index[RUN_START_W-1:0];
					open_len = '0;
				end
				open_len++;
			end else begin
				close_open_run();
			end
			rec_index++;
		end
		if (!l) begin
			return 1'b0;
		end
		close_open_run();
		r.found = (best_len != 0);
		r.run_start = best_start;
		r.run_length = best_len;
		r.distance_qmm = DISTANCE_W'(best_start * DIST_PER_SAMPLE_QMM);
		rec_index = '0;
		best_start = '0;
		best_len = '0;
		open_start = '0;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int unsigned due,
		input int unsigned got);
		if (due != got) begin
			$error("%s: expected %0d, got %0d", name, due, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (echo_results_due.size() == 0) begin
				$error("result word with no expectation waiting");
				mismatches++;
			end else begin
				due_head = echo_results_due.pop_front();
				check_field("found", due_head.found, found);
				check_field("run_start", due_head.run_start, run_start);
				check_field("run_length", due_head.run_length, run_length);
				check_field("distance_qmm", due_head.distance_qmm, distance_qmm);
			end
		end
	end

	// Entered and left at a falling edge. When typed is set, the given result
	// replaces the predicted one in the queue.
	task automatic send_word(input sample_t s, input logic l, input logic typed,
		input echo_result_t typed_res);
		echo_result_t predicted;
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		last <= l;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (track_quiet_run(s, l, predicted)) begin
			echo_results_due.push_back(typed ? typed_res : predicted);
		end
		words_sent++;
		@(negedge clk);
	endtask

	// Holds the input off until every result is back and the pipe is empty.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (echo_results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input sample_t v);
		settle_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		thr_model = v;
	endtask

	function automatic sample_t pick_sample(input bit quiet);
		if (quiet && thr_model != 0) begin
			return sample_t'($urandom_range(thr_model - 1, 0));
		end
		return sample_t'($urandom_range(255, thr_model));
	endfunction

	// Runs of quiet and loud samples with occasional fully random ones.
	task automatic send_record(input int len);
		bit      quiet;
		sample_t s;
		quiet = $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 20) begin
				s = sample_t'($urandom_range(255));
			end else begin
				if ($urandom_range(99) < 35) begin
					quiet = !quiet;
				end
				s = pick_sample(quiet);
			end
			send_word(s, i == len - 1, 1'b0, NONE_DUE);
		end
	endtask

	task automatic send_records(input int target, input bit pause_midway);
		int start_count;
		bit paused;
		start_count = words_sent;
		paused = 1'b0;
		while (words_sent - start_count < target) begin
			send_record($urandom_range(24, 1));
			if (pause_midway && !paused && words_sent - start_count >= target / 2) begin
				settle_idle();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_gap_pct = 7;
		rx_stall_pct = 51;
		foreach (DIRECTED_ROWS[i]) begin
			send_word(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].lst, DIRECTED_ROWS[i].typed,
				DIRECTED_ROWS[i].res);
		end

		// Threshold 0: no sample can be quiet.
		write_threshold(8'd0);
		send_records(150, 1'b0);

		// Threshold 255: everything but 255 is quiet.
		tx_gap_pct = 51;
		rx_stall_pct = 7;
		write_threshold(8'd255);
		send_records(250, 1'b1);

		tx_gap_pct = 0;
		rx_stall_pct = 0;
		write_threshold(sample_t'($urandom_range(254, 1)));
		send_records(220, 1'b0);
		send_records(40, 1'b0);

		settle_idle();
		repeat (6) @(negedge clk);
		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
